FILE: sv/hdwf_pkg.sv
// Package for the hashed duplicate window filter.
// Holds the shared types, the FNV-1a constants and the hash step function.
// No dependencies.
package hdwf_pkg;

   // FNV-1a 32-bit constants and the window reset value.
   localparam logic [31:0] FNV_BASIS    = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME    = 32'd16777619;
   localparam logic [31:0] WINDOW_RESET = 32'd30000;

   // One finished key waiting for its table lookup.
   typedef struct packed {
      logic [31:0] hash;
      logic [31:0] now_ms;
   } job_type;

   // Push request from the front end into the job queue.
   typedef struct packed {
      logic    valid;
      job_type job;
   } q_push_type;

   // Fill status of the job queue.
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // One table slot: a hash and its time stamp.
   typedef struct packed {
      logic [31:0] hash;
      logic [31:0] stamp;
   } slot_type;

   // States of the lookup engine.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } back_state_type;

   // Fold one byte into the running hash: xor, then multiply modulo 2^32.
   function automatic logic [31:0] fnv_step(input logic [31:0] hash, input logic [7:0] data);
      logic [31:0] mixed;
      mixed = hash ^ {24'd0, data};
      return mixed * FNV_PRIME;
   endfunction

endpackage

FILE: sv/hdwf_if.sv
// Channel interfaces of the hashed duplicate window filter.
// hdwf_req_if carries key bytes in, hdwf_rsp_if carries verdicts out.
// No dependencies.
interface hdwf_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  key_byte;
   logic        last_byte;
   logic [31:0] now_ms;

   modport source (output valid, output key_byte, output last_byte, output now_ms,
                   input ready);
   modport sink   (input valid, input key_byte, input last_byte, input now_ms,
                   output ready);
endinterface

interface hdwf_rsp_if;
   logic valid;
   logic ready;
   logic duplicate;

   modport source (output valid, output duplicate, input ready);
   modport sink   (input valid, input duplicate, output ready);
endinterface

FILE: sv/hdwf_front.sv
// Front end: accepts key beats and folds each byte into the FNV-1a hash.
// On the last byte it pushes the finished hash and time into the job queue.
// Depends on hdwf_pkg and hdwf_req_if.
module hdwf_front
   import hdwf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   hdwf_req_if.sink     req_bus,
   input  q_status_type q_status,
   output q_push_type   q_push
);

   logic [31:0] hash_ff;
   logic [31:0] hash_in;
   logic [31:0] hash_next;
   logic        accept;

   // Bytes are taken whenever the queue has room for a finished key.
   assign req_bus.ready = !q_status.full;
   assign accept        = req_bus.valid && req_bus.ready;
   assign hash_next     = fnv_step(hash_ff, req_bus.key_byte);

   // Next hash and queue push.
   always_comb begin
      hash_in          = hash_ff;
      q_push.valid     = 1'b0;
      q_push.job.hash  = hash_next;
      q_push.job.now_ms = req_bus.now_ms;
      if (accept) begin
         if (req_bus.last_byte) begin
            hash_in      = FNV_BASIS;
            q_push.valid = 1'b1;
         end else begin
            hash_in = hash_next;
         end
      end
   end

   // Running hash register.
   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= FNV_BASIS;
      end else begin
         hash_ff <= hash_in;
      end
   end

endmodule

FILE: sv/hdwf_queue.sv
// Two-entry job queue between the hashing front end and the lookup engine.
// Lets either side stall without holding up the other.
// Depends on hdwf_pkg.
module hdwf_queue
   import hdwf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  q_push_type   q_push,
   input  logic         q_pop,
   output job_type      q_job,
   output q_status_type q_status
);

   job_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign q_job          = entry_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == 2'd2);
   assign q_status.empty = (count_ff == 2'd0);

   // Pointer and count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (q_push.valid) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (q_pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      unique case ({q_push.valid, q_pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (q_push.valid) begin
         entry_ff[wr_ptr_ff] <= q_push.job;
      end
   end

endmodule

FILE: sv/hdwf_back.sv
// Lookup engine: scans the slot table one slot a cycle for each queued key,
// then reports the verdict and records new keys. Owns the slot memory.
// Depends on hdwf_pkg and hdwf_rsp_if.
module hdwf_back
   import hdwf_pkg::*;
#(
   parameter int SLOT_COUNT = 24
) (
   input  logic         clock,
   input  logic         reset,
   input  logic [31:0]  window_ms,
   input  job_type      q_job,
   input  q_status_type q_status,
   output logic         q_pop,
   hdwf_rsp_if.source   rsp_bus
);

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

   // Slot memory and its per-entry valid bits.
   slot_type              slot_mem [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] valid_ff;
   slot_type              rd_slot_ff;
   logic                  rd_valid_ff;

   back_state_type state_ff, state_in;
   job_type        job_ff, job_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic           issuing_ff, issuing_in;
   logic           ev_vld_ff, ev_vld_in;
   logic [IDX_W-1:0] ev_idx_ff, ev_idx_in;
   logic           dup_ff, dup_in;
   logic           empty_found_ff, empty_found_in;
   logic [IDX_W-1:0] empty_idx_ff, empty_idx_in;
   logic [31:0]    best_age_ff, best_age_in;
   logic [IDX_W-1:0] victim_ff, victim_in;
   logic           rsp_vld_ff, rsp_vld_in;
   logic           rsp_dup_ff, rsp_dup_in;

   logic           wr_en;
   logic [IDX_W-1:0] wr_idx;
   slot_type       wr_slot;
   logic [31:0]    age;
   logic           hit;

   assign rsp_bus.valid     = rsp_vld_ff;
   assign rsp_bus.duplicate = rsp_dup_ff;

   // Age of the slot read last cycle and its match against the current key.
   assign age = job_ff.now_ms - rd_slot_ff.stamp;
   assign hit = rd_valid_ff && (rd_slot_ff.hash == job_ff.hash) && (age < window_ms);

   // Next state and datapath control.
   always_comb begin
      state_in       = state_ff;
      job_in         = job_ff;
      rd_idx_in      = rd_idx_ff;
      issuing_in     = issuing_ff;
      ev_vld_in      = (state_ff == ST_SCAN) && issuing_ff;
      ev_idx_in      = rd_idx_ff;
      dup_in         = dup_ff;
      empty_found_in = empty_found_ff;
      empty_idx_in   = empty_idx_ff;
      best_age_in    = best_age_ff;
      victim_in      = victim_ff;
      rsp_vld_in     = rsp_vld_ff && !rsp_bus.ready;
      rsp_dup_in     = rsp_dup_ff;
      q_pop          = 1'b0;
      wr_en          = 1'b0;
      wr_idx         = empty_found_ff ? empty_idx_ff : victim_ff;
      wr_slot.hash   = job_ff.hash;
      wr_slot.stamp  = (job_ff.now_ms != 32'd0) ? job_ff.now_ms : 32'd1;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               q_pop          = 1'b1;
               job_in         = q_job;
               rd_idx_in      = '0;
               issuing_in     = 1'b1;
               dup_in         = 1'b0;
               empty_found_in = 1'b0;
               empty_idx_in   = '0;
               best_age_in    = 32'd0;
               victim_in      = '0;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Issue one slot read a cycle.
            if (issuing_ff) begin
               if (rd_idx_ff == LAST_IDX) begin
                  issuing_in = 1'b0;
               end else begin
                  rd_idx_in = rd_idx_ff + IDX_W'(1);
               end
            end
            // Judge the slot whose data came back.
            if (ev_vld_ff) begin
               if (hit) begin
                  dup_in = 1'b1;
               end
               if (!rd_valid_ff && !empty_found_ff) begin
                  empty_found_in = 1'b1;
                  empty_idx_in   = ev_idx_ff;
               end
               if (age >= best_age_ff) begin
                  best_age_in = age;
                  victim_in   = ev_idx_ff;
               end
               if (ev_idx_ff == LAST_IDX) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            // Hand the verdict over once the output register is free.
            if (!rsp_vld_ff || rsp_bus.ready) begin
               rsp_vld_in = 1'b1;
               rsp_dup_in = dup_ff;
               wr_en      = !dup_ff;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         issuing_ff <= 1'b0;
         ev_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         valid_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         issuing_ff <= issuing_in;
         ev_vld_ff  <= ev_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (wr_en) begin
            valid_ff[wr_idx] <= 1'b1;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      job_ff         <= job_in;
      rd_idx_ff      <= rd_idx_in;
      ev_idx_ff      <= ev_idx_in;
      dup_ff         <= dup_in;
      empty_found_ff <= empty_found_in;
      empty_idx_ff   <= empty_idx_in;
      best_age_ff    <= best_age_in;
      victim_ff      <= victim_in;
      rsp_dup_ff     <= rsp_dup_in;
   end

   // Slot memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_idx] <= wr_slot;
      end
      rd_slot_ff  <= slot_mem[rd_idx_ff];
      rd_valid_ff <= valid_ff[rd_idx_ff];
   end

endmodule

FILE: sv/hashed_duplicate_window_filter.sv
// Top level of the hashed duplicate window filter.
// Instantiates hdwf_front, hdwf_queue and hdwf_back; uses hdwf_pkg and hdwf_if.
//
//   Channel   Direction  Signals                                Meaning
//   req_bus   in         valid ready key_byte last_byte now_ms  one key byte per beat
//   rsp_bus   out        valid ready duplicate                  one verdict per key
//   csr_*     in         csr_wr_en csr_wr_data                  window_ms register
//
// The front end takes one key byte per cycle while the two-entry job queue has room.
// For each finished key the lookup engine pops the queue, streams every slot through the
// single memory read port, then hands over the verdict and writes the slot for a new key.
// Reset clears the valid bit of every slot at once, so no clearing pass is needed.
// A stalled rsp_bus holds the verdict; further keys collect in the queue, then
// req_bus.ready drops.
module hashed_duplicate_window_filter
   import hdwf_pkg::*;
#(
   parameter int SLOT_COUNT = 24
) (
   input  logic        clock,
   input  logic        reset,
   hdwf_req_if.sink    req_bus,
   hdwf_rsp_if.source  rsp_bus,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   logic [31:0]  window_ff;
   logic [31:0]  window_in;
   q_push_type   q_push;
   q_status_type q_status;
   job_type      q_job;
   logic         q_pop;

   // Window register.
   assign window_in = csr_wr_en ? csr_wr_data : window_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
      end else begin
         window_ff <= window_in;
      end
   end

   // Hashing front end.
   hdwf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .q_status (q_status),
      .q_push   (q_push)
   );

   // Job queue.
   hdwf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .q_pop    (q_pop),
      .q_job    (q_job),
      .q_status (q_status)
   );

   // Lookup engine.
   hdwf_back #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .window_ms (window_ff),
      .q_job     (q_job),
      .q_status  (q_status),
      .q_pop     (q_pop),
      .rsp_bus   (rsp_bus)
   );

`ifndef SYNTHESIS
   // The front end never pushes into a full queue.
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push.valid |-> !q_status.full)
      else $error("job pushed into a full queue");

   // The engine never pops an empty queue.
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("job popped from an empty queue");

   // A pop starts a scan, so two pops never come back to back.
   a_pop_spacing: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> !q_pop)
      else $error("lookup engine popped twice in a row");
`endif

endmodule

FILE: tb/hdwf_verdict_checker.sv
// Verdict checker for the hashed duplicate window filter testbench.
// Watches the key byte, verdict and register ports, predicts each verdict and compares.
// Depends on hdwf_pkg for the hash constants and the window reset value.
module hdwf_verdict_checker
   import hdwf_pkg::*;
#(
   parameter int SLOT_COUNT = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  key_byte,
   input  logic        last_byte,
   input  logic [31:0] now_ms,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        duplicate,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   output int          fail_count,
   output int          pending_count,
   output int          dup_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // Shadow copy of the block's register and state.
   logic [31:0] window_ms;
   logic [31:0] key_hash;
   logic [31:0] slot_hash [SLOT_COUNT];
   logic [31:0] slot_stamp [SLOT_COUNT];

   // Verdicts predicted but not yet seen on the result channel.
   bit          verdict_q [$];
   int          fails;
   int          dups;

   // Look a finished hash up in the shadow table and record it when it is new.
   // Returns 1 for a duplicate.
   function automatic bit lookup_and_record(input logic [31:0] hash, input logic [31:0] now);
      int          victim;
      bit          have_empty;
      logic [31:0] oldest;
      logic [31:0] age;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (slot_stamp[i] != 32'd0 && slot_hash[i] == hash &&
             (now - slot_stamp[i]) < window_ms) begin
            return 1'b1;
         end
      end
      victim     = 0;
      have_empty = 1'b0;
      oldest     = 32'd0;
      // First empty slot wins; otherwise the oldest, with ties to the higher index.
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (!have_empty && slot_stamp[i] == 32'd0) begin
            victim     = i;
            have_empty = 1'b1;
         end
      end
      if (!have_empty) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            age = now - slot_stamp[i];
            if (age >= oldest) begin
               oldest = age;
               victim = i;
            end
         end
      end
      slot_hash[victim]  = hash;
      // A stamp of zero means empty, so time zero is kept as one.
      slot_stamp[victim] = (now != 32'd0) ? now : 32'd1;
      return 1'b0;
   endfunction

   // Every beat is handled at the clock edge that accepts it.
   always @(posedge clock) begin : watch
      bit want;
      if (reset) begin
         window_ms = WINDOW_RESET;
         key_hash  = FNV_BASIS;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_hash[i]  = 32'd0;
            slot_stamp[i] = 32'd0;
         end
         verdict_q.delete();
         fails = 0;
         dups  = 0;
      end else begin
         // Compare an accepted verdict with the oldest prediction.
         if (rsp_valid && rsp_ready) begin
            if (verdict_q.size() == 0) begin
               $display("%0t: verdict with none expected, expected nothing, actual %0b",
                        $time, duplicate);
               fails++;
            end else begin
               want = verdict_q.pop_front();
               if (duplicate !== want) begin
                  $display("%0t: duplicate mismatch, expected %0b, actual %0b",
                           $time, want, duplicate);
                  fails++;
               end
               if (duplicate === 1'b1) begin
                  dups++;
               end
            end
         end
         // Fold an accepted key byte; the last one triggers the lookup.
         if (req_valid && req_ready) begin
            key_hash = (key_hash ^ {24'd0, key_byte}) * FNV_PRIME;
            if (last_byte) begin
               verdict_q.push_back(lookup_and_record(key_hash, now_ms));
               key_hash = FNV_BASIS;
            end
         end
         if (csr_wr_en) begin
            window_ms = csr_wr_data;
         end
      end
      fail_count    <= fails;
      pending_count <= verdict_q.size();
      dup_count     <= dups;
   end

endmodule

FILE: tb/tb_hashed_duplicate_window_filter.sv
// Top of the hashed duplicate window filter testbench: clock, reset, stimulus and verdict.
// Sends keys from a small pool at chosen times so that repeats, window edges and evictions
// occur. Depends on hdwf_pkg, hdwf_if, the block and hdwf_verdict_checker.
module tb_hashed_duplicate_window_filter;
   timeunit 1ns;
   timeprecision 1ps;
   import hdwf_pkg::*;

   localparam int SLOT_COUNT  = 24;
   localparam int PERIOD      = 10;
   localparam int POOL        = 40;
   localparam int MAX_KEY_LEN = 6;
   localparam int PHASES      = 8;
   localparam int PHASE_BEATS = 215;
   // Drain time after the last verdict: one full lookup plus margin.
   localparam int DRAIN       = 2 * (SLOT_COUNT + 3);
   localparam int LIMIT       = 500000;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;
   logic        sink_ready = 1'b0;
   int          stall_left = 0;
   bit          idle_on = 1'b0;
   int          cycles = 0;

   int          fail_count;
   int          pending_count;
   int          dup_count;
   int          beats_sent = 0;
   int          keys_sent = 0;
   int          settings_used = 0;

   logic [7:0]  pool_bytes [POOL][MAX_KEY_LEN];
   int          pool_len [POOL];

   hdwf_req_if req_bus ();
   hdwf_rsp_if rsp_bus ();

   hashed_duplicate_window_filter #(
      .SLOT_COUNT (SLOT_COUNT)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   hdwf_verdict_checker #(
      .SLOT_COUNT (SLOT_COUNT)
   ) verdict_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_bus.valid),
      .req_ready     (req_bus.ready),
      .key_byte      (req_bus.key_byte),
      .last_byte     (req_bus.last_byte),
      .now_ms        (req_bus.now_ms),
      .rsp_valid     (rsp_bus.valid),
      .rsp_ready     (rsp_bus.ready),
      .duplicate     (rsp_bus.duplicate),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .dup_count     (dup_count)
   );

   always #(PERIOD / 2) clock = ~clock;

   // Result side stalls in random bursts while idling is on.
   assign rsp_bus.ready = sink_ready;
   always @(posedge clock) begin
      if (stall_left > 0) begin
         sink_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         sink_ready <= 1'b0;
         stall_left <= $urandom_range(0, 5);
      end else begin
         sink_ready <= 1'b1;
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("%0t: run did not finish within %0d cycles", $time, LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Offer one beat, after an optional gap, and wait until it is taken.
   task automatic send_beat(input logic [7:0] data, input logic last, input logic [31:0] stamp);
      int gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 6);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.key_byte  <= data;
      req_bus.last_byte <= last;
      req_bus.now_ms    <= stamp;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      beats_sent++;
   endtask

   // Send a whole key; only its last beat carries the real time.
   task automatic send_key(input logic [7:0] bytes [MAX_KEY_LEN], input int len,
                           input logic [31:0] stamp);
      for (int j = 0; j < len; j++) begin
         if (j == len - 1) begin
            send_beat(bytes[j], 1'b1, stamp);
         end else begin
            send_beat(bytes[j], 1'b0, $urandom());
         end
      end
      keys_sent++;
   endtask

   // Wait until every predicted verdict has arrived and the lookup engine is quiet.
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   // Change the window only while the block is idle.
   task automatic set_window(input logic [31:0] value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      settings_used++;
   endtask

   initial begin : stimulus
      logic [31:0] clock_ms;
      logic [31:0] step_max;
      logic [31:0] windows [PHASES];
      logic [7:0]  fresh [MAX_KEY_LEN];
      int          active;
      int          phase_end;
      int          pick;

      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.key_byte  = 8'd0;
      req_bus.last_byte = 1'b0;
      req_bus.now_ms    = 32'd0;
      csr_wr_en         = 1'b0;
      csr_wr_data       = 32'd0;

      for (int k = 0; k < POOL; k++) begin
         for (int j = 0; j < MAX_KEY_LEN; j++) begin
            pool_bytes[k][j] = 8'd0;
         end
         pool_len[k] = 1;
      end
      // Fixed keys for the directed part.
      pool_bytes[0][0] = 8'h00;
      pool_bytes[1][0] = 8'hFF;
      pool_bytes[2][0] = 8'hFF;
      pool_bytes[2][1] = 8'h00;
      pool_bytes[2][2] = 8'hA5;
      pool_bytes[2][3] = 8'h5A;
      pool_len[2]      = 4;
      pool_bytes[3][0] = 8'h41;
      pool_bytes[3][1] = 8'h42;
      pool_len[3]      = 2;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset window: time zero, wrap-around ages, window edges.
      send_key(pool_bytes[0], pool_len[0], 32'd0);
      send_key(pool_bytes[0], pool_len[0], 32'd0);
      send_key(pool_bytes[0], pool_len[0], 32'd5);
      send_key(pool_bytes[1], pool_len[1], 32'hFFFF_FFFF);
      send_key(pool_bytes[1], pool_len[1], 32'd29998);
      send_key(pool_bytes[2], pool_len[2], 32'd100);
      send_key(pool_bytes[2], pool_len[2], 32'd30099);
      send_key(pool_bytes[2], pool_len[2], 32'd30100);
      send_key(pool_bytes[3], pool_len[3], 32'h8000_0000);
      // A zero window never matches.
      set_window(32'd0);
      send_key(pool_bytes[3], pool_len[3], 32'h8000_0000);
      send_key(pool_bytes[0], pool_len[0], 32'd5);
      // A one ms window matches only the same millisecond.
      set_window(32'd1);
      send_key(pool_bytes[1], pool_len[1], 32'd7);
      send_key(pool_bytes[1], pool_len[1], 32'd7);
      send_key(pool_bytes[1], pool_len[1], 32'd8);

      windows[0] = 32'hFFFF_FFFF;
      windows[1] = $urandom_range(2, 200);
      windows[2] = 32'd0;
      windows[3] = WINDOW_RESET;
      windows[4] = $urandom();
      windows[5] = 32'd1;
      windows[6] = $urandom_range(100, 5000);
      windows[7] = $urandom_range(1, 64);

      // Random phases: each draws a new key pool, a pool size and a pace of time.
      for (int p = 0; p < PHASES; p++) begin
         set_window(windows[p]);
         idle_on <= (p == PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
         for (int k = 4; k < POOL; k++) begin
            pool_len[k] = $urandom_range(1, MAX_KEY_LEN);
            for (int j = 0; j < MAX_KEY_LEN; j++) begin
               pool_bytes[k][j] = $urandom();
            end
         end
         // Small pools fit in the table; large ones force evictions.
         active = $urandom_range(4, POOL);
         case ($urandom_range(0, 4))
            0:       step_max = 32'd0;
            1:       step_max = 32'd4;
            2:       step_max = 32'd64;
            3:       step_max = 32'd4096;
            default: step_max = 32'h00FF_FFFF;
         endcase
         clock_ms  = (p % 2 == 1) ? 32'hFFFF_FF00 : $urandom();
         phase_end = beats_sent + PHASE_BEATS;
         while (beats_sent < phase_end) begin
            clock_ms = clock_ms + $urandom_range(0, step_max);
            if ($urandom_range(0, 31) == 0) begin
               clock_ms = $urandom();
            end
            if ($urandom_range(0, 63) == 0) begin
               clock_ms = 32'd0;
            end
            if ($urandom_range(0, 9) == 0) begin
               for (int j = 0; j < MAX_KEY_LEN; j++) begin
                  fresh[j] = $urandom();
               end
               send_key(fresh, $urandom_range(1, MAX_KEY_LEN), clock_ms);
            end else begin
               active = (active < 1) ? 1 : active;
               pick   = $urandom_range(0, active - 1);
               send_key(pool_bytes[pick], pool_len[pick], clock_ms);
            end
         end
      end

      settle();
      $display("Sent %0d key beats in %0d keys over %0d window settings.",
               beats_sent, keys_sent, settings_used + 1);
      $display("%0d keys came back as duplicates; %0d verdicts still owed.",
               dup_count, pending_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
